[sv/sawc_pkg.sv]
// ----------------------------------------------------------------------------
// sawc_pkg
// types and constants of the set-associative write-back cache tag controller
// ----------------------------------------------------------------------------
package sawc_pkg;

    localparam int MAX_SETS_DEF  = 1024;
    localparam int WAYS_DEF      = 8;
    localparam int ADDR_BITS_DEF = 32;

    localparam int TAG_W = 30;
    localparam int AGE_W = 3;
    localparam int CNT_W = 32;
    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    typedef enum logic [1:0] {
        K_READ  = 2'd0,
        K_WRITE = 2'd1,
        K_FLUSH = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_OFFSET = 2'd0,
        CFG_INDEX  = 2'd1,
        CFG_WAYS   = 2'd2,
        CFG_POLICY = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_FLUSH,
        ST_OUT
    } t_state;

endpackage

[sv/set_assoc_writeback_cache_tags.sv]
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags
// tag, state and statistics controller of a set-associative write-back cache
// ----------------------------------------------------------------------------
// A request enters on the input channel (kind, address) when i_in_valid is
// high and o_in_stall is low. One result leaves on the output channel when
// o_out_valid is high and i_out_stall is low; it carries hit, writeback,
// victim tag and the running statistics counters.
// Each set (all ways) is one word of a single synchronous memory. A read or
// write passes through the controller in order: the set read at acceptance,
// then lookup, replacement and write-back of the set word, then the result.
// The block takes no new request until the result of the last one has left.
// A flush walks every set, one a cycle.
// After reset the memory is cleared one set a cycle, while no request is taken;
// configuration writes are accepted at any time.
// While the receiver stalls the result is held and no new request is taken.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache_tags
    import sawc_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_kind,
    input  logic [31:0]          i_address,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit,
    output logic                 o_writeback,
    output logic [TAG_W-1:0]     o_victim_tag,
    output logic [CNT_W-1:0]     o_access_count,
    output logic [CNT_W-1:0]     o_hit_count,
    output logic [CNT_W-1:0]     o_miss_count,
    output logic [CNT_W-1:0]     o_read_count,
    output logic [CNT_W-1:0]     o_write_count,
    output logic [CNT_W-1:0]     o_bytes_in,
    output logic [CNT_W-1:0]     o_bytes_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [3:0]           i_cfg_data
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SCNT_W = $clog2(MAX_SETS + 1);
    localparam int MAXIDX = $clog2(MAX_SETS + 1) - 1;   // floor(log2)
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WCNT_W = $clog2(WAYS + 1);
    localparam int LINE_W = 2 + AGE_W + TAG_W;
    localparam int WORD_W = WAYS * LINE_W;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
        logic [TAG_W-1:0] tag;
    } t_line;

    // configuration
    logic [3:0] r_offset_bits, r_index_bits, r_ways;
    logic       r_policy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 4'd5;
            r_index_bits  <= 4'd6;
            r_ways        <= 4'd4;
            r_policy      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OFFSET: r_offset_bits <= i_cfg_data;
                CFG_INDEX:  r_index_bits  <= i_cfg_data;
                CFG_WAYS:   r_ways        <= i_cfg_data;
                CFG_POLICY: r_policy      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective configuration
    logic [3:0]        eff_off, eff_idx;
    logic [WCNT_W-1:0] eff_ways;

    always_comb begin
        eff_off = r_offset_bits;
        if (r_offset_bits < 4'd2)  eff_off = 4'd2;
        if (r_offset_bits > 4'd12) eff_off = 4'd12;
        eff_idx = (32'(r_index_bits) > MAXIDX) ? 4'(MAXIDX) : r_index_bits;
        if (r_ways == 4'd0)            eff_ways = WCNT_W'(1);
        else if (32'(r_ways) > WAYS)   eff_ways = WCNT_W'(WAYS);
        else                           eff_ways = WCNT_W'(r_ways);
    end

    // set memory
    logic [WORD_W-1:0] r_mem [MAX_SETS];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [SET_W-1:0]  mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // control
    t_state            r_state, n_state;
    logic [SCNT_W-1:0] r_ptr, n_ptr;
    logic [1:0]        r_kind;
    logic [SET_W-1:0]  r_set;
    logic [TAG_W-1:0]  r_tag;
    logic              r_hit, r_wb, n_hit, n_wb;
    logic [TAG_W-1:0]  r_vtag, n_vtag;
    logic [CNT_W-1:0]  r_cnt [7];
    logic [CNT_W-1:0]  n_cnt [7];
    logic [12:0]       block;
    logic [WCNT_W-1:0] fl_dirty;

    logic [SET_W-1:0]  a_set;
    logic [TAG_W-1:0]  a_tag;
    logic [63:0]       a_ext;
    logic [31:0]       set_mask;

    always_comb begin
        a_ext    = 64'(i_address) & ((ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1));
        set_mask = (32'd1 << eff_idx) - 32'd1;
        a_set    = SET_W'((a_ext >> eff_off) & 64'(set_mask));
        a_tag    = TAG_W'(a_ext >> (5'(eff_off) + 5'(eff_idx)));
        block    = 13'd1 << eff_off;
    end

    function automatic logic [CNT_W-1:0] sat(input logic [CNT_W-1:0] a,
                                             input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    t_line lines [WAYS];
    t_line nl    [WAYS];
    logic              found_any, inv_any;
    logic [WAY_W-1:0]  found_w, inv_w, old_w, vic_w;
    logic [AGE_W-1:0]  best;

    always_comb begin
        for (int w = 0; w < WAYS; w++) lines[w] = r_rdata[w*LINE_W +: LINE_W];
        found_any = 1'b0; found_w = '0;
        inv_any = 1'b0; inv_w = '0;
        old_w = '0; best = '0;
        for (int w = WAYS-1; w >= 0; w--) begin
            if (WCNT_W'(w) < eff_ways) begin
                if (lines[w].valid && lines[w].tag == r_tag) begin
                    found_any = 1'b1; found_w = WAY_W'(w);
                end
                if (!lines[w].valid) begin
                    inv_any = 1'b1; inv_w = WAY_W'(w);
                end
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (WCNT_W'(w) < eff_ways && (w == 0 || lines[w].age > best)) begin
                best = lines[w].age; old_w = WAY_W'(w);
            end
        end
        vic_w = inv_any ? inv_w : old_w;
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_hit   = r_hit;
        n_wb    = r_wb;
        n_vtag  = r_vtag;
        fl_dirty = '0;
        for (int j = 0; j < 7; j++) n_cnt[j] = r_cnt[j];
        for (int w = 0; w < WAYS; w++) nl[w] = lines[w];
        mem_we    = 1'b0;
        mem_waddr = r_set;
        mem_raddr = a_set;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = SET_W'(r_ptr);
                for (int w = 0; w < WAYS; w++) nl[w] = '0;
                n_ptr = r_ptr + SCNT_W'(1);
                if (r_ptr == SCNT_W'(MAX_SETS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_hit = 1'b0; n_wb = 1'b0; n_vtag = '0;
                    if (t_kind'(i_kind) == K_FLUSH) begin
                        mem_raddr = '0;
                        n_ptr   = '0;
                        n_state = ST_FLUSH;
                    end else if (t_kind'(i_kind) == K_NONE) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                mem_we = 1'b1;
                n_cnt[0] = sat(r_cnt[0], CNT_W'(1));
                if (t_kind'(r_kind) == K_READ) n_cnt[3] = sat(r_cnt[3], CNT_W'(1));
                else                           n_cnt[4] = sat(r_cnt[4], CNT_W'(1));
                if (found_any) begin
                    n_hit = 1'b1;
                    n_cnt[1] = sat(r_cnt[1], CNT_W'(1));
                    if (t_kind'(r_kind) == K_WRITE) nl[found_w].dirty = 1'b1;
                    if (!r_policy) begin
                        for (int w = 0; w < WAYS; w++)
                            if (WCNT_W'(w) < eff_ways && WAY_W'(w) != found_w &&
                                lines[w].valid && lines[w].age < lines[found_w].age)
                                nl[w].age = lines[w].age + AGE_W'(1);
                        nl[found_w].age = '0;
                    end
                end else begin
                    n_cnt[2] = sat(r_cnt[2], CNT_W'(1));
                    n_cnt[5] = sat(r_cnt[5], CNT_W'(block));
                    if (lines[vic_w].valid && lines[vic_w].dirty) begin
                        n_wb   = 1'b1;
                        n_vtag = lines[vic_w].tag;
                        n_cnt[6] = sat(r_cnt[6], CNT_W'(block));
                    end
                    for (int w = 0; w < WAYS; w++)
                        if (WCNT_W'(w) < eff_ways && WAY_W'(w) != vic_w &&
                            lines[w].valid && lines[w].age < AGE_MAX)
                            nl[w].age = lines[w].age + AGE_W'(1);
                    nl[vic_w].valid = 1'b1;
                    nl[vic_w].tag   = r_tag;
                    nl[vic_w].dirty = (t_kind'(r_kind) == K_WRITE);
                    nl[vic_w].age   = '0;
                end
                n_state = ST_OUT;
            end
            ST_FLUSH: begin
                // r_rdata holds set r_ptr; read the next one ahead
                mem_we    = 1'b1;
                mem_waddr = SET_W'(r_ptr);
                mem_raddr = SET_W'(r_ptr + SCNT_W'(1));
                for (int w = 0; w < WAYS; w++) begin
                    nl[w].valid = 1'b0; nl[w].dirty = 1'b0; nl[w].age = '0;
                end
                // dirty lines of the set counted, then one add of their count times the block size
                for (int w = 0; w < WAYS; w++)
                    if (lines[w].valid && lines[w].dirty) fl_dirty = fl_dirty + WCNT_W'(1);
                if (fl_dirty != '0) begin
                    n_cnt[6] = sat(r_cnt[6], CNT_W'(fl_dirty) << eff_off);
                    n_wb = 1'b1;
                end
                n_ptr = r_ptr + SCNT_W'(1);
                if (r_ptr == SCNT_W'(MAX_SETS - 1)) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        for (int w = 0; w < WAYS; w++) mem_wdata[w*LINE_W +: LINE_W] = nl[w];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ptr   <= '0;
            for (int j = 0; j < 7; j++) r_cnt[j] <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            for (int j = 0; j < 7; j++) r_cnt[j] <= n_cnt[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_kind <= i_kind;
            r_set  <= a_set;
            r_tag  <= a_tag;
        end
        r_hit  <= n_hit;
        r_wb   <= n_wb;
        r_vtag <= n_vtag;
    end

    assign o_out_valid    = (r_state == ST_OUT);
    assign o_hit          = r_hit;
    assign o_writeback    = r_wb;
    assign o_victim_tag   = r_vtag;
    assign o_access_count = r_cnt[0];
    assign o_hit_count    = r_cnt[1];
    assign o_miss_count   = r_cnt[2];
    assign o_read_count   = r_cnt[3];
    assign o_write_count  = r_cnt[4];
    assign o_bytes_in     = r_cnt[5];
    assign o_bytes_out    = r_cnt[6];

endmodule
